/* design/spq_pkg.sv */
// Shared types and constants for the stable priority queue.
// Used by spq_front, spq_cells and stable_priority_queue_top; depends on nothing.

package spq_pkg;

	localparam int VALUE_W   = 32;
	localparam int PRIO_W    = 16;
	localparam int OCC_W     = 5;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_DEQ   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// One decoded operation as it waits between the front and the back.
	typedef struct packed {
		logic                     deq;
		logic [VALUE_W-1:0]       value;
		logic signed [PRIO_W-1:0] prio;
	} op_t;

	// One result item.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
		logic [OCC_W-1:0]   occupancy;
	} res_t;

endpackage

/* design/spq_front.sv */
// Front end of the priority queue: takes input transfers, decodes them into
// operations and holds them in a two-entry queue for the back end. Uses spq_pkg.

module spq_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [spq_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic [0:0]                         s_tuser,
	input  logic                               pop,
	output logic                               op_valid,
	output spq_pkg::op_t                       op
);

	spq_pkg::op_t ent_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         do_pop;
	spq_pkg::op_t new_op;

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign op_valid = (cnt_q != 2'd0);
	assign do_pop   = pop && op_valid;
	assign op       = ent_q[rd_ptr_q];

	always_comb begin
		new_op.deq   = s_tuser[0];
		new_op.value = s_tdata[spq_pkg::VALUE_W-1:0];
		new_op.prio  = s_tdata[spq_pkg::VALUE_W +: spq_pkg::PRIO_W];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* design/spq_cells.sv */
// Back end of the priority queue: a row of sorted cells that compare in
// parallel and shift, plus the result register. Uses spq_pkg.

module spq_cells #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	input  spq_pkg::op_t  op,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_ready,
	output spq_pkg::res_t res
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [spq_pkg::VALUE_W-1:0]       val_q [DEPTH];
	logic signed [spq_pkg::PRIO_W-1:0] pri_q [DEPTH];
	logic [DEPTH-1:0]                  ge;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     count_d;
	logic                              full;
	logic                              empty;
	logic                              upd_enq;
	logic                              upd_deq;
	logic                              res_valid_q;
	spq_pkg::res_t                     res_q;
	spq_pkg::res_t                     res_d;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign pop       = op_valid && (!res_valid_q || res_ready);
	assign upd_enq   = pop && !op.deq && !full;
	assign upd_deq   = pop && op.deq && !empty;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A cell holding an entry of equal or higher priority stays put, so the new
	// entry lands right behind the last of them.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge[i] = (CW'(i) < count_q) && (pri_q[i] >= op.prio);
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic                              up_ge;
		logic [spq_pkg::VALUE_W-1:0]       up_val;
		logic signed [spq_pkg::PRIO_W-1:0] up_pri;
		logic [spq_pkg::VALUE_W-1:0]       dn_val;
		logic signed [spq_pkg::PRIO_W-1:0] dn_pri;

		if (g == 0) begin : g_head
			assign up_ge  = 1'b1;
			assign up_val = op.value;
			assign up_pri = op.prio;
		end else begin : g_body
			assign up_ge  = ge[g-1];
			assign up_val = val_q[g-1];
			assign up_pri = pri_q[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign dn_val = val_q[g];
			assign dn_pri = pri_q[g];
		end else begin : g_inner
			assign dn_val = val_q[g+1];
			assign dn_pri = pri_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (upd_enq && !ge[g]) begin
				if (up_ge) begin
					val_q[g] <= op.value;
					pri_q[g] <= op.prio;
				end else begin
					val_q[g] <= up_val;
					pri_q[g] <= up_pri;
				end
			end else if (upd_deq) begin
				val_q[g] <= dn_val;
				pri_q[g] <= dn_pri;
			end
		end
	end

	always_comb begin
		count_d         = count_q;
		res_d.value     = '0;
		res_d.status    = spq_pkg::ST_ENQ;
		if (op.deq) begin
			if (empty) begin
				res_d.status = spq_pkg::ST_EMPTY;
			end else begin
				res_d.status = spq_pkg::ST_DEQ;
				res_d.value  = val_q[0];
				count_d      = count_q - CW'(1);
			end
		end else begin
			if (full) begin
				res_d.status = spq_pkg::ST_FULL;
			end else begin
				count_d = count_q + CW'(1);
			end
		end
		res_d.occupancy = spq_pkg::OCC_W'(count_d);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				count_q     <= count_d;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/stable_priority_queue_top.sv */
// Stable priority queue, top level: front queue and sorted cell row.
// Each result passes through a front queue entry and then the result register.
// Throughput: one item per cycle while m_tready holds; every cell compares and shifts in parallel.
// A two-entry queue between front and back lets either side stall alone.
// Reset (arst_n, asynchronous, active low) empties the queue and the store.
// Depends on spq_pkg, spq_front and spq_cells.

module stable_priority_queue_top #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [31:0] item_value, [47:32] item_priority
	input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] mode
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] out_value, [36:32] occupancy, [39:37] zero
	output logic [spq_pkg::M_TDATA_W-1:0] m_tdata,
	// [1:0] status
	output logic [1:0]                    m_tuser
);

	spq_pkg::op_t  op;
	logic          op_valid;
	logic          pop;
	spq_pkg::res_t res;

	spq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.pop      (pop),
		.op_valid (op_valid),
		.op       (op)
	);

	spq_cells #(
		.DEPTH (DEPTH)
	) u_cells (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {3'b000, res.occupancy, res.value};
	assign m_tuser = res.status;

	a_empty_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == spq_pkg::ST_EMPTY) |-> (m_tdata[36:32] == '0))
		else $error("dequeue on empty reported a nonzero occupancy");

	a_full_means_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == spq_pkg::ST_FULL) |->
			(m_tdata[36:32] == spq_pkg::OCC_W'(DEPTH)))
		else $error("dropped enqueue while the store was not full");

	a_value_only_on_deq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[31:0] != '0) |-> (m_tuser == spq_pkg::ST_DEQ))
		else $error("nonzero data on a result that is not a dequeue");

endmodule

/* bench/spq_result_checker.sv */
// Result checker for the stable priority queue: watches both stream channels,
// keeps its own sorted store and compares every result transfer in order.
// Depends on spq_pkg for the status codes and the result layout.
`timescale 1ns / 1ps

module spq_result_checker #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// [31:0] item_value, [47:32] item_priority
	input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] mode
	input  logic [0:0]                    s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] out_value, [36:32] occupancy, [39:37] zero
	input  logic [spq_pkg::M_TDATA_W-1:0] m_tdata,
	// [1:0] status
	input  logic [1:0]                    m_tuser,
	output int                            failures,
	output int                            pending
);

	logic [spq_pkg::VALUE_W-1:0]       slot_value [DEPTH];
	logic signed [spq_pkg::PRIO_W-1:0] slot_prio  [DEPTH];
	int                                held;
	spq_pkg::res_t                     expected_results [$];

	// Applies one operation to the local sorted store and returns its result.
	function automatic spq_pkg::res_t apply_queue_op(
		input logic                              deq,
		input logic [spq_pkg::VALUE_W-1:0]       value,
		input logic signed [spq_pkg::PRIO_W-1:0] prio
	);
		spq_pkg::res_t r;
		int            pos;
		int            i;
		r.value = '0;
		if (!deq) begin
			if (held >= DEPTH) begin
				r.status = spq_pkg::ST_FULL;
			end else begin
				// Equal priorities stay ahead, which keeps arrival order.
				pos = 0;
				while (pos < held && slot_prio[pos] >= prio)
					pos++;
				for (i = held; i > pos; i--) begin
					slot_value[i] = slot_value[i-1];
					slot_prio[i]  = slot_prio[i-1];
				end
				slot_value[pos] = value;
				slot_prio[pos]  = prio;
				held++;
				r.status = spq_pkg::ST_ENQ;
			end
		end else begin
			if (held == 0) begin
				r.status = spq_pkg::ST_EMPTY;
			end else begin
				r.value = slot_value[0];
				for (i = 1; i < held; i++) begin
					slot_value[i-1] = slot_value[i];
					slot_prio[i-1]  = slot_prio[i];
				end
				held--;
				r.status = spq_pkg::ST_DEQ;
			end
		end
		r.occupancy = held[spq_pkg::OCC_W-1:0];
		return r;
	endfunction

	initial begin
		failures = 0;
		pending  = 0;
		held     = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		spq_pkg::res_t want;
		if (!arst_n) begin
			held = 0;
			expected_results.delete();
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_queue_op(s_tuser[0],
					s_tdata[31:0], s_tdata[47:32]));
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transfer: out_value %h status %0d",
						m_tdata[31:0], m_tuser);
					failures++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[31:0] !== want.value) begin
						$error("out_value: expected %h, got %h", want.value, m_tdata[31:0]);
						failures++;
					end
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						failures++;
					end
					if (m_tdata[36:32] !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d", want.occupancy,
							m_tdata[36:32]);
						failures++;
					end
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

/* bench/testbench.sv */
// Top of the stable priority queue bench: clock, reset, stream stimulus with
// random idling on both channels, and the final verdict.
// Depends on spq_pkg, stable_priority_queue_top and spq_result_checker.
`timescale 1ns / 1ps

module testbench;

	localparam int   DEPTH       = 16;
	localparam int   RANDOM_OPS  = 1900;
	localparam int   QUIET_OPS   = 150;
	localparam int   CYCLE_LIMIT = 400000;
	localparam logic MODE_ENQ    = 1'b0;
	localparam logic MODE_DEQ    = 1'b1;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [spq_pkg::S_TDATA_W-1:0] s_tdata;
	logic [0:0]                    s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [spq_pkg::M_TDATA_W-1:0] m_tdata;
	logic [1:0]                    m_tuser;
	int                            failures;
	int                            pending;

	int cycle_count;
	bit no_idle;
	int tx_calm;
	int rx_calm;
	int rx_stall;
	bit rx_ready_next;

	stable_priority_queue_top #(.DEPTH(DEPTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	spq_result_checker #(.DEPTH(DEPTH)) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.failures (failures),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count = cycle_count + 1;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Receiver: random stall bursts, with calm stretches and none near the end.
	initial begin
		m_tready = 1'b0;
		rx_stall = 0;
		rx_calm  = 0;
	end

	always @(negedge clk) begin
		if (no_idle) begin
			rx_ready_next = 1'b1;
		end else if (rx_stall > 0) begin
			rx_ready_next = 1'b0;
			rx_stall--;
		end else begin
			rx_ready_next = 1'b1;
			if (rx_calm > 0)
				rx_calm--;
			else if ($urandom_range(0, 39) == 0)
				rx_calm = $urandom_range(20, 80);
			else if ($urandom_range(0, 5) == 0)
				rx_stall = $urandom_range(1, 9);
		end
		m_tready <= rx_ready_next;
	end

	// Presents one item and holds it until the transfer; a gap may come first.
	task automatic push_op(input logic mode, input logic [31:0] value,
		input logic [15:0] prio);
		int gap;
		gap = 0;
		if (!no_idle) begin
			if (tx_calm > 0)
				tx_calm--;
			else if ($urandom_range(0, 39) == 0)
				tx_calm = $urandom_range(20, 80);
			else if ($urandom_range(0, 4) == 0)
				gap = $urandom_range(1, 9);
		end
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {prio, value};
		s_tuser  <= mode;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain_queue();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_prio(input int style);
		case (style)
			0: pick_prio = 16'($signed($urandom_range(0, 4)) - 2);
			1: pick_prio = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			default: pick_prio = 16'($urandom);
		endcase
	endfunction

	logic [15:0] fill_prio [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'h8000};

	initial begin
		int   done;
		int   seg_len;
		int   bias;
		int   prio_style;
		logic mode;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		arst_n   = 1'b0;
		no_idle  = 1'b0;
		tx_calm  = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part: empty dequeue, extremes, equal priorities, full store.
		push_op(MODE_DEQ, 32'hffff_ffff, 16'hffff);
		push_op(MODE_ENQ, 32'h7fff_ffff, 16'h0000);
		push_op(MODE_ENQ, 32'h8000_0000, 16'h0000);
		push_op(MODE_ENQ, 32'h0000_0000, 16'h7fff);
		push_op(MODE_ENQ, 32'hffff_ffff, 16'h8000);
		push_op(MODE_ENQ, 32'h1234_5678, 16'h0000);
		push_op(MODE_DEQ, 32'h0000_0000, 16'h0000);
		push_op(MODE_DEQ, 32'h5555_5555, 16'haaaa);
		for (int i = 0; i < DEPTH - 3; i++)
			push_op(MODE_ENQ, 32'(i) * 32'h1111_1111, fill_prio[i % 4]);
		push_op(MODE_ENQ, 32'hdead_beef, 16'h7fff);
		push_op(MODE_DEQ, 32'h0, 16'h0);
		push_op(MODE_DEQ, 32'h0, 16'h0);

		// Hold the sender until every result is back.
		drain_queue();

		// Random part in segments that lean toward filling or draining.
		done = 0;
		while (done < RANDOM_OPS) begin
			seg_len    = $urandom_range(20, 80);
			bias       = $urandom_range(0, 2);
			prio_style = $urandom_range(0, 3);
			for (int k = 0; k < seg_len && done < RANDOM_OPS; k++) begin
				if (done == RANDOM_OPS / 2)
					drain_queue();
				if (done == RANDOM_OPS - QUIET_OPS)
					no_idle = 1'b1;
				case (bias)
					0: mode = ($urandom_range(0, 9) < 8) ? MODE_ENQ : MODE_DEQ;
					1: mode = ($urandom_range(0, 9) < 8) ? MODE_DEQ : MODE_ENQ;
					default: mode = $urandom_range(0, 1) ? MODE_DEQ : MODE_ENQ;
				endcase
				push_op(mode, $urandom, pick_prio(prio_style));
				done++;
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
